// ----- design/dlc_pkg.sv -----
package dlc_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int QUEUE_DEPTH         = 4;
    localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] SERVER_PORT = 16'd53;
    localparam logic [63:0] V4_MASK     = 64'hFFFF_FFFF_0000_0000;

    localparam logic [1:0] ROLE_UNKNOWN  = 2'd0;
    localparam logic [1:0] ROLE_CLIENT   = 2'd1;
    localparam logic [1:0] ROLE_BACKEND  = 2'd2;
    localparam logic [1:0] ROLE_UPSTREAM = 2'd3;

    typedef enum logic [1:0] {
        REQ_INS_LOCAL   = 2'd0,
        REQ_INS_BACKEND = 2'd1,
        REQ_CLASSIFY    = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INS_LOCAL,
        CMD_INS_BACKEND,
        CMD_LOOKUP
    } t_cmd_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOC_RD,
        S_LOC_CMP,
        S_BE_RD,
        S_BE_CMP,
        S_EMIT
    } t_back_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        is_v6;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [15:0] src_port_num;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] dst_port_num;
    } t_in_word;

    typedef struct packed {
        logic [1:0] leg_role;
        logic       srv_is_local;
        logic       insert_dropped;
    } t_out_word;

    typedef struct packed {
        t_cmd_kind   kind;
        logic        v6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } t_cmd;

    typedef struct packed {
        logic        v6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } t_entry;

    typedef struct packed {
        logic      pop;
        logic      wr_loc;
        logic      wr_be;
        logic      cmd_load;
        logic      idx_clr;
        logic      idx_inc;
        logic      res_load;
        t_out_word res;
        logic      out_load;
    } t_back_ctrl;

    // Entries and commands both hold the address already masked to its family.
    function automatic logic entry_match(t_entry e, t_cmd c);
        entry_match = (e.v6 == c.v6) && (e.addr_hi == c.addr_hi) && (e.addr_lo == c.addr_lo);
    endfunction

endpackage

// ----- design/dlc_front.sv -----
module dlc_front
    import dlc_pkg::*;
(
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_data,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic        srv_dst;
    logic        srv_src;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    assign srv_dst = (i_in_data.dst_port_num == SERVER_PORT) &&
                     (i_in_data.src_port_num != SERVER_PORT);
    assign srv_src = (i_in_data.src_port_num == SERVER_PORT) &&
                     (i_in_data.dst_port_num != SERVER_PORT);

    // keep only the significant bytes for IPv4
    assign src_hi = i_in_data.is_v6 ? i_in_data.src_addr_hi : (i_in_data.src_addr_hi & V4_MASK);
    assign src_lo = i_in_data.is_v6 ? i_in_data.src_addr_lo : 64'd0;
    assign dst_hi = i_in_data.is_v6 ? i_in_data.dst_addr_hi : (i_in_data.dst_addr_hi & V4_MASK);
    assign dst_lo = i_in_data.is_v6 ? i_in_data.dst_addr_lo : 64'd0;

    always_comb begin
        o_cmd.kind    = CMD_NONE;
        o_cmd.v6      = i_in_data.is_v6;
        o_cmd.addr_hi = src_hi;
        o_cmd.addr_lo = src_lo;
        case (i_in_data.req_type)
            REQ_INS_LOCAL: begin
                o_cmd.kind = CMD_INS_LOCAL;
            end
            REQ_INS_BACKEND: begin
                o_cmd.kind = CMD_INS_BACKEND;
            end
            REQ_CLASSIFY: begin
                if (srv_dst) begin
                    o_cmd.kind    = CMD_LOOKUP;
                    o_cmd.addr_hi = dst_hi;
                    o_cmd.addr_lo = dst_lo;
                end else if (srv_src) begin
                    o_cmd.kind = CMD_LOOKUP;
                end
            end
            default: begin
                o_cmd.kind = CMD_NONE;
            end
        endcase
    end

endmodule

// ----- design/dlc_cmd_queue.sv -----
module dlc_cmd_queue
    import dlc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_empty
);

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + QUEUE_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - QUEUE_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- design/dlc_back.sv -----
module dlc_back
    import dlc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_q_head,
    input  logic      i_q_empty,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_entry           r_loc_mem [TABLE_DEPTH];
    t_entry           r_be_mem  [TABLE_DEPTH];
    t_entry           r_loc_rd;
    t_entry           r_be_rd;
    t_back_state      r_state;
    t_back_state      n_state;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_loc_cnt;
    logic [CNT_W-1:0] r_be_cnt;
    t_out_word        r_res;
    logic             r_out_valid;
    t_out_word        r_out;
    t_back_ctrl       ctrl;
    t_entry           head_entry;
    logic             loc_full;
    logic             be_full;
    logic             loc_hit;
    logic             be_hit;
    logic             loc_last;
    logic             be_last;
    logic             out_free;

    assign head_entry = '{v6: i_q_head.v6, addr_hi: i_q_head.addr_hi, addr_lo: i_q_head.addr_lo};
    assign loc_full   = (r_loc_cnt == CNT_W'(TABLE_DEPTH));
    assign be_full    = (r_be_cnt == CNT_W'(TABLE_DEPTH));
    assign loc_hit    = entry_match(r_loc_rd, r_cmd);
    assign be_hit     = entry_match(r_be_rd, r_cmd);
    assign loc_last   = ((r_idx + CNT_W'(1)) == r_loc_cnt);
    assign be_last    = ((r_idx + CNT_W'(1)) == r_be_cnt);
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_q_pop     = ctrl.pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_head.kind == CMD_LOOKUP) begin
                        if (r_loc_cnt != '0) begin
                            n_state = S_LOC_RD;
                        end else if (r_be_cnt != '0) begin
                            n_state = S_BE_RD;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_LOC_RD: begin
                n_state = S_LOC_CMP;
            end
            S_LOC_CMP: begin
                if (loc_hit) begin
                    n_state = S_EMIT;
                end else if (loc_last) begin
                    n_state = (r_be_cnt != '0) ? S_BE_RD : S_EMIT;
                end else begin
                    n_state = S_LOC_RD;
                end
            end
            S_BE_RD: begin
                n_state = S_BE_CMP;
            end
            S_BE_CMP: begin
                n_state = (be_hit || be_last) ? S_EMIT : S_BE_RD;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    ctrl.pop      = 1'b1;
                    ctrl.res_load = 1'b1;
                    case (i_q_head.kind)
                        CMD_INS_LOCAL: begin
                            ctrl.wr_loc             = !loc_full;
                            ctrl.res.insert_dropped = loc_full;
                        end
                        CMD_INS_BACKEND: begin
                            ctrl.wr_be              = !be_full;
                            ctrl.res.insert_dropped = be_full;
                        end
                        CMD_LOOKUP: begin
                            ctrl.cmd_load     = 1'b1;
                            ctrl.idx_clr      = 1'b1;
                            ctrl.res.leg_role = ROLE_UPSTREAM;
                        end
                        default: begin
                            ctrl.res.leg_role = ROLE_UNKNOWN;
                        end
                    endcase
                end
            end
            S_LOC_CMP: begin
                if (loc_hit) begin
                    ctrl.res_load         = 1'b1;
                    ctrl.res.leg_role     = ROLE_CLIENT;
                    ctrl.res.srv_is_local = 1'b1;
                end else if (loc_last) begin
                    ctrl.idx_clr = 1'b1;
                end else begin
                    ctrl.idx_inc = 1'b1;
                end
            end
            S_BE_CMP: begin
                if (be_hit) begin
                    ctrl.res_load     = 1'b1;
                    ctrl.res.leg_role = ROLE_BACKEND;
                end else if (!be_last) begin
                    ctrl.idx_inc = 1'b1;
                end
            end
            S_EMIT: begin
                ctrl.out_load = out_free;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loc_cnt   <= '0;
            r_be_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctrl.wr_loc) begin
                r_loc_cnt <= r_loc_cnt + CNT_W'(1);
            end
            if (ctrl.wr_be) begin
                r_be_cnt <= r_be_cnt + CNT_W'(1);
            end
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.cmd_load) begin
            r_cmd <= i_q_head;
        end
        if (ctrl.idx_clr) begin
            r_idx <= '0;
        end else if (ctrl.idx_inc) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (ctrl.res_load) begin
            r_res <= ctrl.res;
        end
        if (ctrl.out_load) begin
            r_out <= r_res;
        end
    end

    // table memories: write at the fill count, registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (ctrl.wr_loc) begin
            r_loc_mem[r_loc_cnt[IDX_W-1:0]] <= head_entry;
        end
        r_loc_rd <= r_loc_mem[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.wr_be) begin
            r_be_mem[r_be_cnt[IDX_W-1:0]] <= head_entry;
        end
        r_be_rd <= r_be_mem[r_idx[IDX_W-1:0]];
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_loc_cnt <= CNT_W'(TABLE_DEPTH)) && (r_be_cnt <= CNT_W'(TABLE_DEPTH)))
        else $error("table fill count beyond depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LOC_CMP) |-> (r_idx < r_loc_cnt)) and
        ((r_state == S_BE_CMP) |-> (r_idx < r_be_cnt)))
        else $error("scan index past filled entries");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.pop |-> (!i_q_empty && (r_state == S_IDLE)))
        else $error("pop from empty queue or while busy");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && r_out_valid && !i_out_ready) |=>
        ((r_state == S_EMIT) && $stable(r_out)))
        else $error("result emitted over a waiting word");

endmodule

// ----- design/dns_leg_classifier.sv -----
// DNS leg classifier. Insert words fill a local and a backend address table
// (TABLE_DEPTH entries each, a full table drops the insert and flags it);
// classify words pick the port-53 endpoint and look its address up, local
// table first, then backend. The front accepts one word per cycle, unless
// the four-deep command queue is full; the back works one command at a
// time. An insert, or a packet without a single port-53 side, goes from idle
// straight to the emit state in the back. A lookup scans local, then backend
// entries one at a time through the registered memory read port, each in a
// read then a compare state, until a hit or until all local_count +
// backend_count entries are read. Tables need no clearing after reset.
module dns_leg_classifier
    import dlc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_cmd front_cmd;
    t_cmd q_head;

    dlc_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    dlc_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    dlc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_head    (q_head),
        .i_q_empty   (q_empty),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
